@@ src/sld_pkg.sv @@
`default_nettype none
package sld_pkg;

	localparam logic [7:0] SYNC_FIRST  = 8'hAA;
	localparam logic [7:0] SYNC_SECOND = 8'h55;

	localparam int unsigned LEN_W = 18;
	localparam int unsigned IDX_W = 17;

	// Largest value an 18-bit limit register can hold
	localparam int unsigned LEN_MAX = (1 << LEN_W) - 1;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} byte_stage_t;

	typedef struct packed {
		logic [7:0]       payload_byte;
		logic [IDX_W-1:0] byte_index;
		logic [LEN_W-1:0] frame_length;
		logic             frame_end;
		logic             bad_length;
	} res_t;

endpackage
`default_nettype wire

@@ src/sld_intf.sv @@
`default_nettype none
interface sld_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sld_res_if;
	logic        valid;
	logic        ready;
	logic [7:0]  payload_byte;
	logic [16:0] byte_index;
	logic [17:0] frame_length;
	logic        frame_end;
	logic        bad_length;

	modport source (output valid, output payload_byte, output byte_index,
		output frame_length, output frame_end, output bad_length, input ready);
	modport sink (input valid, input payload_byte, input byte_index,
		input frame_length, input frame_end, input bad_length, output ready);
endinterface

interface sld_cfg_if;
	logic        valid;
	logic        ready;
	logic [17:0] max_frame_length;

	modport source (output valid, output max_frame_length, input ready);
	modport sink (input valid, input max_frame_length, output ready);
endinterface
`default_nettype wire

@@ src/sld_in_stage.sv @@
`default_nettype none
module sld_in_stage (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire  [7:0]          in_data,
	output logic                in_ready,
	output sld_pkg::byte_stage_t stage,
	input  wire                 stage_ready
);
	import sld_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       advance;
	logic       load;

	assign advance  = valid_s1 && stage_ready;
	assign in_ready = !valid_s1 || stage_ready;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_s1 <= in_data;
		end
	end

	assign stage.valid = valid_s1;
	assign stage.data  = data_s1;

endmodule
`default_nettype wire

@@ src/sld_parse_core.sv @@
`default_nettype none
module sld_parse_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  sld_pkg::byte_stage_t   stage,
	output logic                         stage_ready,
	input  wire  [sld_pkg::LEN_W-1:0]    limit,
	output logic                         res_valid,
	output sld_pkg::res_t                res,
	input  wire                          res_ready
);
	import sld_pkg::*;

	typedef enum logic [1:0] {
		PH_HUNT0 = 2'd0,
		PH_HUNT1 = 2'd1,
		PH_LEN   = 2'd2,
		PH_DATA  = 2'd3
	} phase_t;

	phase_t           phase_q, phase_n;
	logic [1:0]       cnt_q, cnt_n;
	logic [LEN_W-1:0] len_q, len_n;
	logic             hi_q, hi_n;
	logic [LEN_W-1:0] decl_q, decl_n;
	logic [IDX_W-1:0] off_q, off_n;

	logic             res_valid_s2;
	res_t             res_s2;
	logic             has_res;
	res_t             res_n;
	logic             fire;

	logic [7:0]       b;
	logic [LEN_W-1:0] next_off;
	logic             last;
	logic             is_zero;
	logic             is_bad;
	logic [LEN_W-1:0] lim_p1;

	assign stage_ready = !res_valid_s2 || res_ready;
	assign fire        = stage.valid && stage_ready;
	assign b           = stage.data;
	assign next_off    = {1'b0, off_q} + LEN_W'(1);
	assign last        = next_off >= decl_q;
	assign lim_p1      = limit + LEN_W'(1);

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		len_n   = len_q;
		hi_n    = hi_q;
		decl_n  = decl_q;
		off_n   = off_q;
		has_res = 1'b0;
		res_n   = '0;
		is_zero = 1'b0;
		is_bad  = 1'b0;
		case (phase_q)
			PH_HUNT0: begin
				if (b == SYNC_FIRST) begin
					phase_n = PH_HUNT1;
				end
			end
			PH_HUNT1: begin
				if (b == SYNC_SECOND) begin
					phase_n = PH_LEN;
					cnt_n   = 2'd0;
					len_n   = '0;
					hi_n    = 1'b0;
				end else if (b != SYNC_FIRST) begin
					phase_n = PH_HUNT0;
				end
			end
			PH_LEN: begin
				// Keep the low 18 bits of the length; fold the rest into a nonzero flag
				case (cnt_q)
					2'd0: len_n[7:0]   = b;
					2'd1: len_n[15:8]  = b;
					2'd2: begin
						len_n[17:16] = b[1:0];
						hi_n         = hi_q || (b[7:2] != 6'd0);
					end
					default: hi_n = hi_q || (b != 8'd0);
				endcase
				if (cnt_q != 2'd3) begin
					cnt_n = cnt_q + 2'd1;
				end else begin
					cnt_n   = 2'd0;
					is_zero = (len_n == '0) && !hi_n;
					is_bad  = is_zero || hi_n || (len_n > limit);
					if (is_bad) begin
						// A nonzero bad length always exceeds the limit, so it reports limit plus one
						has_res            = 1'b1;
						res_n.bad_length   = 1'b1;
						res_n.frame_length = is_zero ? '0 : lim_p1;
						phase_n            = PH_HUNT0;
					end else begin
						decl_n  = len_n;
						off_n   = '0;
						phase_n = PH_DATA;
					end
				end
			end
			default: begin
				has_res            = 1'b1;
				res_n.payload_byte = b;
				res_n.byte_index   = off_q;
				res_n.frame_length = decl_q;
				res_n.frame_end    = last;
				off_n              = next_off[IDX_W-1:0];
				if (last) begin
					phase_n = PH_HUNT0;
					off_n   = '0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HUNT0;
			cnt_q        <= 2'd0;
			len_q        <= '0;
			hi_q         <= 1'b0;
			decl_q       <= '0;
			off_q        <= '0;
			res_valid_s2 <= 1'b0;
			res_s2       <= '0;
		end else begin
			if (fire) begin
				phase_q      <= phase_n;
				cnt_q        <= cnt_n;
				len_q        <= len_n;
				hi_q         <= hi_n;
				decl_q       <= decl_n;
				off_q        <= off_n;
				res_valid_s2 <= has_res;
				if (has_res) begin
					res_s2 <= res_n;
				end
			end else if (res_ready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	assign res_valid = res_valid_s2;
	assign res       = res_s2;

	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_s2.bad_length |->
			!res_s2.frame_end && res_s2.byte_index == '0 && res_s2.payload_byte == 8'd0)
		else $error("bad-length result carries payload fields");

	a_off_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> {1'b0, off_q} < decl_q)
		else $error("payload offset reached declared length");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 && res_s2.frame_end |->
			{1'b0, res_s2.byte_index} + LEN_W'(1) >= res_s2.frame_length)
		else $error("frame end before last byte");

	a_cnt_len_only: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd0 |-> phase_q == PH_LEN)
		else $error("length count outside length phase");

endmodule
`default_nettype wire

@@ src/sync_length_frame_deframer.sv @@
// Sync and length frame deframer.
// rx carries one received byte per transfer. The block hunts for the sync pair
// 0xAA 0x55, gathers a four-byte little-endian length and then passes each
// payload byte out on res with its offset, the declared length and a frame end
// mark on the last byte. A zero length, or one above the limit, gives a single
// bad-length result and the hunt restarts. Sync and length bytes give no result.
// The limit is the smaller of the cfg register (reset MAX_FRAME_BYTES) and
// MAX_FRAME_BYTES; write it only while no frame is in flight.
// Throughput is one byte per cycle while res takes results: an input register
// feeds the parser, whose decode is a single pass into the result register.
// A byte goes through the input register, then the result register, to res.
// Reset empties both registers and returns the parser to the hunt.
// When res stalls the result register holds and the parser stops; once the input
// register is full rx.ready falls in the same cycle as res.ready; nothing is lost.
`default_nettype none
module sync_length_frame_deframer #(
	parameter int unsigned MAX_FRAME_BYTES = 131072
) (
	input  wire     clk,
	input  wire     arst_n,
	sld_byte_if.sink  rx,
	sld_res_if.source res,
	sld_cfg_if.sink   cfg
);
	import sld_pkg::*;

	localparam int unsigned         CAP     = (MAX_FRAME_BYTES > LEN_MAX) ? LEN_MAX
		: MAX_FRAME_BYTES;
	localparam logic [LEN_W-1:0]    CAP_L   = LEN_W'(CAP);
	localparam logic [LEN_W-1:0]    RST_LIM = LEN_W'(MAX_FRAME_BYTES);

	logic [LEN_W-1:0] max_len_q;
	logic [LEN_W-1:0] limit;
	byte_stage_t      stage;
	logic             stage_ready;
	logic             res_valid;
	res_t             res_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= RST_LIM;
		end else if (cfg.valid) begin
			max_len_q <= cfg.max_frame_length;
		end
	end

	assign limit = (max_len_q > CAP_L) ? CAP_L : max_len_q;

	sld_in_stage u_in (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (rx.valid),
		.in_data     (rx.rx_byte),
		.in_ready    (rx.ready),
		.stage       (stage),
		.stage_ready (stage_ready)
	);

	sld_parse_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.stage       (stage),
		.stage_ready (stage_ready),
		.limit       (limit),
		.res_valid   (res_valid),
		.res         (res_data),
		.res_ready   (res.ready)
	);

	assign res.valid        = res_valid;
	assign res.payload_byte = res_data.payload_byte;
	assign res.byte_index   = res_data.byte_index;
	assign res.frame_length = res_data.frame_length;
	assign res.frame_end    = res_data.frame_end;
	assign res.bad_length   = res_data.bad_length;

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
module tb_top;
	import sld_pkg::*;

	localparam int unsigned FRAME_CAP = 131072;

	typedef enum logic [1:0] {
		HUNT_FIRST,
		HUNT_SECOND,
		GATHER_LEN,
		PASS_DATA
	} deframe_phase_t;

	typedef enum {
		QUIET,
		SRC_GAPS,
		SINK_STALLS,
		BOTH_GAPS
	} pace_t;

	typedef struct {
		logic [7:0] rx;
		bit         typed;
		res_t       want;
	} stim_row_t;

	typedef struct {
		logic [17:0] limit;
		pace_t       pace;
		int unsigned items;
		bit          long_frame;
	} run_phase_t;

	logic clk;
	logic arst_n;

	sld_byte_if rx_if();
	sld_res_if  res_if();
	sld_cfg_if  cfg_if();

	sync_length_frame_deframer #(
		.MAX_FRAME_BYTES(FRAME_CAP)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx_if),
		.res   (res_if),
		.cfg   (cfg_if)
	);

	// Deframer state as the block should hold it
	deframe_phase_t phase_now   = HUNT_FIRST;
	logic [1:0]     len_cnt     = '0;
	logic [31:0]    len_acc     = '0;
	logic [17:0]    frame_len   = '0;
	logic [16:0]    next_idx    = '0;
	logic [17:0]    limit_reg   = 18'(FRAME_CAP);

	res_t        deframed_q[$];
	int unsigned src_gap_pct    = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned errors         = 0;
	int unsigned bytes_sent     = 0;
	int unsigned frame_items    = 0;
	int unsigned results_seen   = 0;
	int unsigned bad_seen       = 0;
	int unsigned ends_seen      = 0;
	int unsigned limits_written = 0;

	stim_row_t dir_rows [23] = '{
		'{SYNC_FIRST, 1'b0, '0},
		'{SYNC_FIRST, 1'b0, '0},   // repeated first sync byte: keep waiting for the second
		'{SYNC_SECOND, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b1, '{8'h00, 17'd0, 18'd0, 1'b0, 1'b1}},   // zero length
		'{SYNC_FIRST, 1'b0, '0},
		'{8'h13, 1'b0, '0},        // broken sync: back to the hunt
		'{SYNC_FIRST, 1'b0, '0},
		'{SYNC_SECOND, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'hFF, 1'b1, '{8'h00, 17'd0, 18'(FRAME_CAP + 1), 1'b0, 1'b1}},   // top byte set
		'{SYNC_FIRST, 1'b0, '0},
		'{SYNC_SECOND, 1'b0, '0},
		'{8'h02, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'hFF, 1'b1, '{8'hFF, 17'd0, 18'd2, 1'b0, 1'b0}},
		'{8'h00, 1'b1, '{8'h00, 17'd1, 18'd2, 1'b1, 1'b0}}
	};

	run_phase_t phases [7] = '{
		'{18'(FRAME_CAP), QUIET, 150, 1'b0},
		'{18'(LEN_MAX), SRC_GAPS, 150, 1'b0},
		'{18'd1, SINK_STALLS, 120, 1'b0},
		'{18'd0, BOTH_GAPS, 100, 1'b0},
		'{18'd7, SRC_GAPS, 150, 1'b0},
		'{18'd33, BOTH_GAPS, 150, 1'b1},
		'{18'd16, SINK_STALLS, 150, 1'b0}
	};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Advance the deframer by one byte; returns 1 when the byte gives a result
	function automatic bit deframe_byte(input logic [7:0] b, output res_t r);
		logic [31:0] lim;
		logic [31:0] nxt;
		bit          got;
		r   = '0;
		got = 1'b0;
		case (phase_now)
			HUNT_FIRST: begin
				if (b == SYNC_FIRST)
					phase_now = HUNT_SECOND;
			end
			HUNT_SECOND: begin
				if (b == SYNC_SECOND) begin
					phase_now = GATHER_LEN;
					len_cnt   = '0;
					len_acc   = '0;
				end else if (b != SYNC_FIRST) begin
					phase_now = HUNT_FIRST;
				end
			end
			GATHER_LEN: begin
				len_acc = len_acc | (32'(b) << (8 * len_cnt));
				if (len_cnt != 2'd3) begin
					len_cnt = len_cnt + 2'd1;
				end else begin
					len_cnt = '0;
					lim = (32'(limit_reg) > FRAME_CAP) ? FRAME_CAP : 32'(limit_reg);
					if (len_acc == 0 || len_acc > lim) begin
						// report the length clamped to one past the limit
						r.frame_length = (len_acc > lim + 1) ? 18'(lim + 1) : len_acc[17:0];
						r.bad_length   = 1'b1;
						phase_now      = HUNT_FIRST;
						got            = 1'b1;
					end else begin
						frame_len = len_acc[17:0];
						next_idx  = '0;
						phase_now = PASS_DATA;
					end
				end
			end
			PASS_DATA: begin
				nxt            = 32'(next_idx) + 1;
				r.payload_byte = b;
				r.byte_index   = next_idx;
				r.frame_length = frame_len;
				r.frame_end    = (nxt >= 32'(frame_len));
				got            = 1'b1;
				next_idx       = nxt[16:0];
				if (r.frame_end) begin
					phase_now = HUNT_FIRST;
					next_idx  = '0;
				end
			end
		endcase
		return got;
	endfunction

	// Enter at a falling edge, leave at the falling edge after the transfer
	task automatic push_byte(input logic [7:0] b, input bit typed, input res_t want);
		res_t r;
		bit   got;
		while ($urandom_range(1, 100) <= src_gap_pct) begin
			rx_if.valid <= 1'b0;
			@(negedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		got = deframe_byte(b, r);
		if (typed)
			deframed_q.push_back(want);
		else if (got)
			deframed_q.push_back(r);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Hold the sender until every awaited result has arrived
	task automatic settle();
		rx_if.valid <= 1'b0;
		do @(negedge clk); while (deframed_q.size() != 0);
	endtask

	task automatic write_limit(input logic [17:0] v);
		settle();
		// a length byte may still sit in the pipe without a result
		repeat (4) @(negedge clk);
		cfg_if.valid            <= 1'b1;
		cfg_if.max_frame_length <= v;
		do @(posedge clk); while (!cfg_if.ready);
		limit_reg = v;
		limits_written++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	task automatic send_frame(input logic [31:0] len, input bit good);
		push_byte(SYNC_FIRST, 1'b0, '0);
		if ($urandom_range(0, 4) == 0)
			push_byte(SYNC_FIRST, 1'b0, '0);
		push_byte(SYNC_SECOND, 1'b0, '0);
		for (int k = 0; k < 4; k++)
			push_byte(len[8*k +: 8], 1'b0, '0);
		frame_items += 6;
		if (good) begin
			for (int unsigned k = 0; k < len; k++)
				push_byte(8'($urandom), 1'b0, '0);
			frame_items += len;
		end
	endtask

	task automatic random_frame(input int unsigned eff);
		int unsigned pick;
		int unsigned hi;
		logic [31:0] len;
		logic [7:0]  b;
		pick = $urandom_range(0, 99);
		b    = 8'($urandom);
		// keep the second sync byte out of noise so only real headers open a frame
		if (b == SYNC_SECOND)
			b = 8'h56;
		if (pick < 8) begin
			push_byte(b, 1'b0, '0);
		end else if (pick < 14) begin
			push_byte(SYNC_FIRST, 1'b0, '0);
			push_byte(b, 1'b0, '0);
		end else if (pick < 26 || eff == 0) begin
			case ($urandom_range(0, 3))
				0:       len = '0;
				1:       len = eff + 1;
				2:       len = eff + 1 + $urandom_range(0, 300000);
				default: len = {8'($urandom_range(1, 255)), 24'($urandom)};
			endcase
			send_frame(len, 1'b0);
		end else begin
			hi  = (eff < 24) ? eff : 24;
			len = $urandom_range(1, hi);
			if (eff <= 64 && $urandom_range(0, 7) == 0)
				len = eff;
			send_frame(len, 1'b1);
		end
	endtask

	task automatic flag_result(input string what, input res_t want, input res_t seen);
		errors++;
		if (errors <= 10)
			$display("%0t: %s: want byte %02h idx %0d len %0d end %b bad %b, got byte %02h idx %0d len %0d end %b bad %b",
				$time, what, want.payload_byte, want.byte_index, want.frame_length,
				want.frame_end, want.bad_length, seen.payload_byte, seen.byte_index,
				seen.frame_length, seen.frame_end, seen.bad_length);
	endtask

	initial begin
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_if.ready <= ($urandom_range(1, 100) > sink_stall_pct);
		end
	end

	always @(posedge clk) begin : check_res
		res_t seen;
		res_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			seen = '{res_if.payload_byte, res_if.byte_index, res_if.frame_length,
				res_if.frame_end, res_if.bad_length};
			results_seen++;
			if (seen.bad_length)
				bad_seen++;
			if (seen.frame_end)
				ends_seen++;
			if (deframed_q.size() == 0) begin
				flag_result("result with nothing awaited", '0, seen);
			end else begin
				want = deframed_q.pop_front();
				if (seen.payload_byte !== want.payload_byte || seen.byte_index !== want.byte_index
						|| seen.frame_length !== want.frame_length
						|| seen.frame_end !== want.frame_end
						|| seen.bad_length !== want.bad_length)
					flag_result("result mismatch", want, seen);
			end
		end
	end

	initial begin
		arst_n                  = 1'b0;
		rx_if.valid             = 1'b0;
		rx_if.rx_byte           = '0;
		cfg_if.valid            = 1'b0;
		cfg_if.max_frame_length = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			push_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].want);

		foreach (phases[p]) begin
			write_limit(phases[p].limit);
			case (phases[p].pace)
				QUIET: begin
					src_gap_pct    = 0;
					sink_stall_pct = 0;
				end
				SRC_GAPS: begin
					src_gap_pct    = 56;
					sink_stall_pct = 0;
				end
				SINK_STALLS: begin
					src_gap_pct    = 0;
					sink_stall_pct = 56;
				end
				BOTH_GAPS: begin
					src_gap_pct    = 35;
					sink_stall_pct = 35;
				end
			endcase
			frame_items = 0;
			while (frame_items < phases[p].items) begin
				random_frame((32'(phases[p].limit) > FRAME_CAP) ? FRAME_CAP : phases[p].limit);
				if ($urandom_range(0, 39) == 0)
					settle();
			end
			// one frame of the largest length the block accepts under this limit
			if (phases[p].long_frame)
				send_frame((32'(phases[p].limit) > FRAME_CAP) ? FRAME_CAP : phases[p].limit,
					1'b1);
		end

		settle();
		repeat (8) @(posedge clk);
		if (deframed_q.size() != 0) begin
			errors += deframed_q.size();
			$display("tb_top: %0d results never arrived", deframed_q.size());
		end
		$display("tb_top: %0d bytes sent over %0d limit settings and four pacing modes",
			bytes_sent, limits_written);
		$display("tb_top: %0d results checked, %0d bad lengths, %0d frame ends",
			results_seen, bad_seen, ends_seen);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("tb_top: timed out with %0d results awaited", deframed_q.size());
		$display("tb_top: done, errors");
		$finish;
	end

endmodule

@@ sim.f @@
src/sld_pkg.sv
src/sld_intf.sv
src/sld_in_stage.sv
src/sld_parse_core.sv
src/sync_length_frame_deframer.sv
tb/tb_top.sv
